@@ rtl/core/rst_pkg.sv @@
// rst_pkg: operation and status codes and the cell control word of the range set table
// no dependencies
package rst_pkg;

   localparam logic [3:0] OP_SET       = 4'd0;
   localparam logic [3:0] OP_CLEAR     = 4'd1;
   localparam logic [3:0] OP_CLEAR_ALL = 4'd2;
   localparam logic [3:0] OP_INSERT    = 4'd3;
   localparam logic [3:0] OP_ERASE     = 4'd4;
   localparam logic [3:0] OP_COVERED   = 4'd5;
   localparam logic [3:0] OP_ANY       = 4'd6;
   localparam logic [3:0] OP_FIRST     = 4'd7;
   localparam logic [3:0] OP_LAST      = 4'd8;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_OVERFLOW = 2'd2;

   typedef struct packed {
      logic load;
      logic shift;
      logic commit;
      logic wr_a;
      logic wr_b;
   } cell_ctl_type;

endpackage

@@ rtl/core/rst_cell.sv @@
// rst_cell: one table slot holding the live range, a scan copy and the rebuilt range
// depends on rst_pkg
module rst_cell #(
   parameter int OFFSET_BITS = 48
) (
   input  logic                     clock,
   input  rst_pkg::cell_ctl_type    ctl,
   input  logic [OFFSET_BITS-1:0]   nbr_start,
   input  logic [OFFSET_BITS:0]     nbr_size,
   input  logic [OFFSET_BITS-1:0]   emit_a_start,
   input  logic [OFFSET_BITS:0]     emit_a_size,
   input  logic [OFFSET_BITS-1:0]   emit_b_start,
   input  logic [OFFSET_BITS:0]     emit_b_size,
   output logic [OFFSET_BITS-1:0]   scan_start,
   output logic [OFFSET_BITS:0]     scan_size
);
   import rst_pkg::*;

   logic [OFFSET_BITS-1:0] main_start_ff, main_start_in;
   logic [OFFSET_BITS:0]   main_size_ff, main_size_in;
   logic [OFFSET_BITS-1:0] scan_start_ff, scan_start_in;
   logic [OFFSET_BITS:0]   scan_size_ff, scan_size_in;
   logic [OFFSET_BITS-1:0] new_start_ff, new_start_in;
   logic [OFFSET_BITS:0]   new_size_ff, new_size_in;

   always_comb begin
      main_start_in = main_start_ff;
      main_size_in  = main_size_ff;
      scan_start_in = scan_start_ff;
      scan_size_in  = scan_size_ff;
      new_start_in  = new_start_ff;
      new_size_in   = new_size_ff;
      if (ctl.load) begin
         scan_start_in = main_start_ff;
         scan_size_in  = main_size_ff;
      end else if (ctl.shift) begin
         scan_start_in = nbr_start;
         scan_size_in  = nbr_size;
      end
      if (ctl.wr_a) begin
         new_start_in = emit_a_start;
         new_size_in  = emit_a_size;
      end else if (ctl.wr_b) begin
         new_start_in = emit_b_start;
         new_size_in  = emit_b_size;
      end
      if (ctl.commit) begin
         main_start_in = new_start_ff;
         main_size_in  = new_size_ff;
      end
   end

   always_ff @(posedge clock) begin
      main_start_ff <= main_start_in;
      main_size_ff  <= main_size_in;
      scan_start_ff <= scan_start_in;
      scan_size_ff  <= scan_size_in;
      new_start_ff  <= new_start_in;
      new_size_ff   <= new_size_in;
   end

   assign scan_start = scan_start_ff;
   assign scan_size  = scan_size_ff;

endmodule

@@ rtl/core/range_set_table_unit.sv @@
// range_set_table_unit: sorted table of disjoint byte ranges with edit and query requests
// depends on rst_pkg and rst_cell
//
// req channel: tuser carries the operation, tdata the window offset and length.
// rsp channel: one word per request with status, query answer, found range and
// the number of ranges held afterwards.
// on a request the live table is copied into a scan chain that shifts one slot
// a cycle towards slot 0, where a single step unit looks at one range per cycle
// and appends up to two rebuilt ranges into the cells. an edit that fits is
// committed into all cells at once at the end; a full table or an offset
// overflow leaves the table as it was.
// a request answers once the step unit has passed every range held; clear-all,
// zero length set, clear and insert, overflowing edits and unknown operations
// do not load the scan chain and answer without a scan.
// a new request is taken once the previous one has reached the output register,
// even while that word waits; a stalled receiver holds the word and the block
// finishes its next request and then waits for the output register.
// reset empties the table and drops any word in flight.
module range_set_table_unit #(
   parameter int MAX_RANGES  = 64,
   parameter int OFFSET_BITS = 48
) (
   input  logic clock,
   input  logic reset,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   input  logic [((2*OFFSET_BITS+7)/8)*8-1:0]          req_tdata,   // op_offset, op_length
   input  logic [3:0]                                  req_tuser,   // req_type
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // status, hit, found_index, found_offset, found_length, range_count
   output logic [((3+$clog2(MAX_RANGES)+2*OFFSET_BITS+$clog2(MAX_RANGES+1)+7)/8)*8-1:0]
                                                       rsp_tdata
);
   import rst_pkg::*;

   localparam int OB      = OFFSET_BITS;
   localparam int SW      = OFFSET_BITS + 1;
   localparam int EW      = OFFSET_BITS + 2;
   localparam int IW      = $clog2(MAX_RANGES);
   localparam int CW      = $clog2(MAX_RANGES + 1);
   localparam int RSP_RAW = 3 + IW + 2 * OFFSET_BITS + CW;
   localparam int RSP_W   = ((RSP_RAW + 7) / 8) * 8;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [3:0]    op_ff, op_in;
   logic [OB-1:0] off_ff, off_in;
   logic [OB-1:0] len_ff, len_in;
   logic [SW-1:0] wend_ff, wend_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] nu_ff, nu_in;
   logic          full_ff, full_in;
   logic          ovf_ff, ovf_in;
   logic          edit_ff, edit_in;
   logic          placed_ff, placed_in;
   logic [OB-1:0] ns_ff, ns_in;
   logic [SW-1:0] ne_ff, ne_in;
   logic          any_ff, any_in;
   logic          joined_ff, joined_in;
   logic [OB-1:0] b_ff, b_in;
   logic [SW-1:0] elast_ff, elast_in;
   logic          hit_ff, hit_in;
   logic [IW-1:0] fidx_ff, fidx_in;
   logic [OB-1:0] foff_ff, foff_in;
   logic [SW-1:0] flen_ff, flen_in;
   logic [1:0]    status_ff, status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic [OB-1:0] scan_start [MAX_RANGES];
   logic [SW-1:0] scan_size  [MAX_RANGES];
   cell_ctl_type  ctl        [MAX_RANGES];

   logic          accept, scan_go, step_en, out_free, commit_ok;
   logic [1:0]    emit_k;
   logic [OB-1:0] a_start, b_start;
   logic [SW-1:0] a_size, b_size;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign step_en    = (state_ff == ST_SCAN);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit_ok  = edit_ff && !full_ff && !((op_ff == OP_INSERT) && ovf_ff);

   always_comb begin
      logic [3:0]    r_op;
      logic [OB-1:0] r_off, r_len;
      logic [SW-1:0] r_wend;
      logic          r_edit, r_query, r_ovf, r_noop;
      logic [EW-1:0] off_e, len_e, wend_e, lim_e, qend_e, hs_e, he_e, ptmp;
      logic [OB-1:0] hs;
      logic [SW-1:0] hz;
      logic          hv, p1, p2, pj;
      logic [CW:0]   nsum;

      state_in = state_ff;  op_in = op_ff;  off_in = off_ff;  len_in = len_ff;
      wend_in = wend_ff;  idx_in = idx_ff;  cnt_in = cnt_ff;  nu_in = nu_ff;
      full_in = full_ff;  ovf_in = ovf_ff;  edit_in = edit_ff;  placed_in = placed_ff;
      ns_in = ns_ff;  ne_in = ne_ff;  any_in = any_ff;  joined_in = joined_ff;
      b_in = b_ff;  elast_in = elast_ff;  hit_in = hit_ff;  fidx_in = fidx_ff;
      foff_in = foff_ff;  flen_in = flen_ff;  status_in = status_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_data_in = rsp_data_ff;
      emit_k = 2'd0;  a_start = '0;  a_size = '0;  b_start = '0;  b_size = '0;
      scan_go = 1'b0;

      r_op    = req_tuser;
      r_off   = req_tdata[OB-1:0];
      r_len   = req_tdata[2*OB-1:OB];
      r_wend  = SW'(r_off) + SW'(r_len);
      r_edit  = (r_op == OP_SET) || (r_op == OP_CLEAR) || (r_op == OP_INSERT)
                || (r_op == OP_ERASE);
      r_query = (r_op == OP_COVERED) || (r_op == OP_ANY) || (r_op == OP_FIRST)
                || (r_op == OP_LAST);
      r_ovf   = r_edit && (r_wend > (SW'(1) << OB))
                && !((r_len == '0) && (r_op != OP_ERASE));
      r_noop  = ((r_op == OP_SET) || (r_op == OP_CLEAR) || (r_op == OP_INSERT))
                && (r_len == '0);

      off_e  = EW'(off_ff);
      len_e  = EW'(len_ff);
      wend_e = EW'(wend_ff);
      lim_e  = EW'(1) << OB;
      qend_e = (wend_e > lim_e) ? lim_e : wend_e;
      hs     = scan_start[0];
      hz     = scan_size[0];
      hs_e   = EW'(hs);
      he_e   = EW'(hs) + EW'(hz);
      hv     = (idx_ff < cnt_ff);
      p1 = 1'b0;  p2 = 1'b0;  pj = 1'b0;  ptmp = '0;
      nsum = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               scan_go   = !r_ovf && ((r_edit && !r_noop) || r_query);
               op_in     = r_op;
               off_in    = r_off;
               len_in    = r_len;
               wend_in   = r_wend;
               idx_in    = '0;
               nu_in     = '0;
               full_in   = 1'b0;
               ovf_in    = 1'b0;
               placed_in = 1'b0;
               any_in    = 1'b0;
               joined_in = 1'b0;
               ns_in     = r_off;
               ne_in     = r_wend;
               hit_in    = 1'b0;
               fidx_in   = '0;
               foff_in   = '0;
               flen_in   = '0;
               edit_in   = scan_go && r_edit;
               status_in = r_ovf ? STAT_OVERFLOW : STAT_OK;
               if (r_op == OP_CLEAR_ALL) begin
                  cnt_in = '0;
               end
               state_in = scan_go ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            case (op_ff)
               OP_SET: begin
                  if (hv) begin
                     if (he_e < off_e) begin
                        emit_k = 2'd1;  a_start = hs;  a_size = hz;
                     end else if (hs_e > wend_e) begin
                        if (!placed_ff) begin
                           emit_k = 2'd2;
                           a_start = ns_ff;  a_size = ne_ff - SW'(ns_ff);
                           b_start = hs;     b_size = hz;
                           placed_in = 1'b1;
                        end else begin
                           emit_k = 2'd1;  a_start = hs;  a_size = hz;
                        end
                     end else begin
                        if (hs < ns_ff) ns_in = hs;
                        if (he_e > EW'(ne_ff)) ne_in = SW'(he_e);
                     end
                  end else if (!placed_ff) begin
                     emit_k = 2'd1;  a_start = ns_ff;  a_size = ne_ff - SW'(ns_ff);
                  end
               end
               OP_CLEAR: begin
                  if (hv) begin
                     if ((he_e <= off_e) || (hs_e >= wend_e)) begin
                        emit_k = 2'd1;  a_start = hs;  a_size = hz;
                     end else begin
                        p1 = (hs < off_ff);
                        p2 = (he_e > wend_e);
                        if (p1) begin
                           emit_k  = p2 ? 2'd2 : 2'd1;
                           a_start = hs;  a_size = SW'(off_e - hs_e);
                           b_start = OB'(wend_ff);  b_size = SW'(he_e - wend_e);
                        end else if (p2) begin
                           emit_k  = 2'd1;
                           a_start = OB'(wend_ff);  a_size = SW'(he_e - wend_e);
                        end
                     end
                  end
               end
               OP_INSERT: begin
                  if (hv) begin
                     if (hs_e >= off_e) begin
                        if (he_e + len_e > lim_e) ovf_in = 1'b1;
                        emit_k = 2'd1;  a_start = hs + len_ff;  a_size = hz;
                     end else if (he_e > off_e) begin
                        if (he_e + len_e > lim_e) ovf_in = 1'b1;
                        emit_k  = 2'd2;
                        a_start = hs;  a_size = SW'(off_e - hs_e);
                        b_start = OB'(wend_ff);  b_size = SW'(he_e - off_e);
                     end else begin
                        emit_k = 2'd1;  a_start = hs;  a_size = hz;
                     end
                  end
               end
               OP_ERASE: begin
                  if (hv && (he_e < off_e)) begin
                     emit_k = 2'd1;  a_start = hs;  a_size = hz;
                  end else if (hv && (hs_e <= wend_e)) begin
                     if (!any_ff) b_in = (hs < off_ff) ? hs : off_ff;
                     any_in   = 1'b1;
                     elast_in = SW'(he_e);
                  end else begin
                     if (any_ff && !joined_ff) begin
                        joined_in = 1'b1;
                        if (EW'(elast_ff) > wend_e) begin
                           pj = 1'b1;
                           ptmp = EW'(elast_ff) - len_e - EW'(b_ff);
                        end else if (b_ff < off_ff) begin
                           pj = 1'b1;
                           ptmp = off_e - EW'(b_ff);
                        end
                     end
                     if (pj) begin
                        a_start = b_ff;  a_size = SW'(ptmp);
                        b_start = hs - len_ff;  b_size = hz;
                        emit_k  = hv ? 2'd2 : 2'd1;
                     end else if (hv) begin
                        a_start = hs - len_ff;  a_size = hz;
                        emit_k  = 2'd1;
                     end
                  end
               end
               default: begin
                  if (hv) begin
                     if (op_ff == OP_COVERED) begin
                        if ((hs_e <= off_e) && (he_e >= wend_e)) hit_in = 1'b1;
                     end else if ((hs_e < qend_e) && (he_e > off_e)) begin
                        if (op_ff == OP_ANY) begin
                           if (len_ff != '0) hit_in = 1'b1;
                        end else if ((op_ff == OP_LAST) || !hit_ff) begin
                           hit_in  = 1'b1;
                           fidx_in = idx_ff[IW-1:0];
                           foff_in = hs;
                           flen_in = hz;
                        end
                     end
                  end
               end
            endcase
            nsum = (CW+1)'(nu_ff) + (CW+1)'(emit_k);
            if (nsum > (CW+1)'(MAX_RANGES)) begin
               full_in = 1'b1;
               nu_in   = CW'(MAX_RANGES);
            end else begin
               nu_in = nsum[CW-1:0];
            end
            idx_in = idx_ff + CW'(1);
            if (idx_ff == cnt_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               if (edit_ff) begin
                  if ((op_ff == OP_INSERT) && ovf_ff) status_in = STAT_OVERFLOW;
                  else if (full_ff) status_in = STAT_FULL;
                  else status_in = STAT_OK;
               end
               if (commit_ok) begin
                  cnt_in = nu_ff;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({cnt_in, flen_ff[OB-1:0], foff_ff, fidx_ff,
                                      hit_ff, status_in});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;      off_ff    <= off_in;     len_ff    <= len_in;
      wend_ff   <= wend_in;    idx_ff    <= idx_in;     nu_ff     <= nu_in;
      full_ff   <= full_in;    ovf_ff    <= ovf_in;     edit_ff   <= edit_in;
      placed_ff <= placed_in;  ns_ff     <= ns_in;      ne_ff     <= ne_in;
      any_ff    <= any_in;     joined_ff <= joined_in;  b_ff      <= b_in;
      elast_ff  <= elast_in;   hit_ff    <= hit_in;     fidx_ff   <= fidx_in;
      foff_ff   <= foff_in;    flen_ff   <= flen_in;    status_ff <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   genvar j;
   generate
      for (j = 0; j < MAX_RANGES; j++) begin : g_cell
         logic [OB-1:0] nbr_start;
         logic [SW-1:0] nbr_size;

         if (j == MAX_RANGES - 1) begin : g_tail
            assign nbr_start = '0;
            assign nbr_size  = '0;
         end else begin : g_link
            assign nbr_start = scan_start[j+1];
            assign nbr_size  = scan_size[j+1];
         end

         assign ctl[j].load   = accept && scan_go;
         assign ctl[j].shift  = step_en;
         assign ctl[j].commit = (state_ff == ST_DONE) && out_free && commit_ok;
         assign ctl[j].wr_a   = step_en && (emit_k != 2'd0) && (nu_ff == CW'(j));
         assign ctl[j].wr_b   = step_en && (emit_k == 2'd2)
                                && (((CW+1)'(nu_ff) + (CW+1)'(1)) == (CW+1)'(j));

         rst_cell #(
            .OFFSET_BITS (OFFSET_BITS)
         ) u_cell (
            .clock        (clock),
            .ctl          (ctl[j]),
            .nbr_start    (nbr_start),
            .nbr_size     (nbr_size),
            .emit_a_start (a_start),
            .emit_a_size  (a_size),
            .emit_b_start (b_start),
            .emit_b_size  (b_size),
            .scan_start   (scan_start[j]),
            .scan_size    (scan_size[j])
         );
      end
   endgenerate

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= cnt_ff))
      else $error("scan index ran past the table");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff <= CW'(MAX_RANGES)) && (nu_ff <= CW'(MAX_RANGES) || state_ff == ST_IDLE))
      else $error("range count beyond table size");

   a_no_full_commit: assert property (@(posedge clock) disable iff (reset)
      ctl[0].commit |-> (!full_ff && edit_ff))
      else $error("table committed after an overflowing rebuild");

endmodule
